### rtl/nrc_pkg.sv
package nrc_pkg;

	localparam int NibW    = 4;
	localparam int Symbols = 16;
	localparam int CountW  = 12;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 64;
	localparam int PlugMax = 8;

	typedef logic [NibW-1:0]   nib_t;
	typedef logic [CfgW-1:0]   wiring_t;
	typedef logic [CountW-1:0] count_t;

	localparam wiring_t IDENTITY_WIRING = 64'hFEDC_BA98_7654_3210;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ROTOR_FIRST  = 3'd0,
		REG_ROTOR_SECOND = 3'd1,
		REG_ROTOR_THIRD  = 3'd2,
		REG_REFLECTOR    = 3'd3,
		REG_PLUG_LIST    = 3'd4,
		REG_PLUG_COUNT   = 3'd5,
		REG_START_POS    = 3'd6
	} cfg_reg_t;

	// Rotor positions used for one byte.
	typedef struct packed {
		nib_t p2;
		nib_t p1;
		nib_t p0;
	} rotor_pos_t;

	// Machine settings shared by both halves of the datapath.
	typedef struct packed {
		wiring_t rotor_first;
		wiring_t rotor_second;
		wiring_t rotor_third;
		wiring_t reflector;
		wiring_t plug_list;
		nib_t    plug_count;
		count_t  start_pos;
	} cipher_cfg_t;

	function automatic nib_t entry_of(input wiring_t table_w, input nib_t idx);
		return table_w[{idx, 2'b00} +: NibW];
	endfunction

	// Lowest index i whose wiring entry at (i + pos) equals c, zero if absent.
	function automatic nib_t rotor_forward(input wiring_t w, input nib_t pos, input nib_t c);
		nib_t r;
		nib_t k;
		r = '0;
		for (int i = Symbols - 1; i >= 0; i--) begin
			k = nib_t'(i) + pos;
			if (entry_of(w, k) == c) begin
				r = nib_t'(i);
			end
		end
		return r;
	endfunction

	function automatic nib_t rotor_backward(input wiring_t w, input nib_t pos, input nib_t c);
		nib_t k;
		k = c + pos;
		return entry_of(w, k);
	endfunction

	// The first entry in use that holds c maps it to its partner.
	function automatic nib_t plugboard(input wiring_t list, input nib_t count, input nib_t c);
		nib_t used;
		nib_t r;
		logic hit;
		used = (count > nib_t'(PlugMax)) ? nib_t'(PlugMax) : count;
		r    = c;
		hit  = 1'b0;
		for (int i = 0; i < Symbols; i++) begin
			if (!hit && (nib_t'(i >> 1) < used) && (entry_of(list, nib_t'(i)) == c)) begin
				r   = entry_of(list, nib_t'(i ^ 1));
				hit = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### rtl/nibble_rotor_cipher.sv
// Nibble rotor cipher: a three-rotor machine with reflector and plugboard over
// sixteen 4-bit symbols. Each byte presented on data_byte is ciphered nibble by
// nibble, and result_byte returns the high and low result nibbles in place. The
// rotor positions for a byte are the start positions plus the three digits of a
// 12-bit byte counter, which advances once per accepted transaction and wraps
// at 4096. The block takes one byte per clock cycle while the output side is not
// stalled. A result passes through the input register, the register between the
// forward and backward halves of the rotor path, and the output register before
// it is presented on result_byte.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// and must be written only while no transaction is in flight.
module nibble_rotor_cipher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [nrc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [nrc_pkg::CfgW-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   result_byte
);
	import nrc_pkg::*;

	cipher_cfg_t cfg_q;
	count_t      step_count_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	rotor_pos_t  pos_s1;

	logic        valid_s2;
	logic [7:0]  mid_s2;
	rotor_pos_t  pos_s2;

	logic        out_valid_q;
	logic [7:0]  result_q;

	logic        en_out;
	logic        en_s2;
	logic        en_s1;
	logic        in_accept;
	rotor_pos_t  pos_next;
	logic [7:0]  mid_next;
	logic [7:0]  result_next;

	// Each stage moves whenever the stage after it is empty or moving, so bubbles
	// are squeezed out and a full pipe still takes a byte per cycle while results are taken.
	assign en_out    = !out_valid_q || out_ready;
	assign en_s2     = !valid_s2 || en_out;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_ready  = en_s1;
	assign in_accept = in_valid && en_s1;

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	// Positions for the incoming byte come from the current counter value.
	always_comb begin
		pos_next.p0 = cfg_q.start_pos[3:0]  + step_count_q[3:0];
		pos_next.p1 = cfg_q.start_pos[7:4]  + step_count_q[7:4];
		pos_next.p2 = cfg_q.start_pos[11:8] + step_count_q[11:8];
	end

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotor_first  <= IDENTITY_WIRING;
			cfg_q.rotor_second <= IDENTITY_WIRING;
			cfg_q.rotor_third  <= IDENTITY_WIRING;
			cfg_q.reflector    <= IDENTITY_WIRING;
			cfg_q.plug_list    <= '0;
			cfg_q.plug_count   <= '0;
			cfg_q.start_pos    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROTOR_FIRST:  cfg_q.rotor_first  <= cfg_data;
				REG_ROTOR_SECOND: cfg_q.rotor_second <= cfg_data;
				REG_ROTOR_THIRD:  cfg_q.rotor_third  <= cfg_data;
				REG_REFLECTOR:    cfg_q.reflector    <= cfg_data;
				REG_PLUG_LIST:    cfg_q.plug_list    <= cfg_data;
				REG_PLUG_COUNT:   cfg_q.plug_count   <= cfg_data[NibW-1:0];
				REG_START_POS:    cfg_q.start_pos    <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// The byte counter steps once per accepted input transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
		end else if (in_accept) begin
			step_count_q <= step_count_q + count_t'(1);
		end
	end

	// Per nibble: the forward half (plugboard and the rotors toward the reflector) and the backward half.
	for (genvar n = 0; n < 2; n++) begin : g_nib
		nrc_fwd_path u_fwd (
			.cfg     (cfg_q),
			.pos     (pos_s1),
			.sym_in  (byte_s1[n*NibW +: NibW]),
			.sym_out (mid_next[n*NibW +: NibW])
		);
		nrc_bwd_path u_bwd (
			.cfg     (cfg_q),
			.pos     (pos_s2),
			.sym_in  (mid_s2[n*NibW +: NibW]),
			.sym_out (result_next[n*NibW +: NibW])
		);
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			pos_s1  <= pos_next;
		end
		if (en_s2 && valid_s1) begin
			mid_s2 <= mid_next;
			pos_s2 <= pos_s1;
		end
		if (en_out && valid_s2) begin
			result_q <= result_next;
		end
	end

endmodule

### rtl/nrc_fwd_path.sv
module nrc_fwd_path (
	input  nrc_pkg::cipher_cfg_t cfg,
	input  nrc_pkg::rotor_pos_t  pos,
	input  nrc_pkg::nib_t        sym_in,
	output nrc_pkg::nib_t        sym_out
);
	import nrc_pkg::*;

	nib_t plugged;
	nib_t after_first;
	nib_t after_second;

	// Plugboard, then the three rotors in the forward direction.
	always_comb begin
		plugged      = plugboard(cfg.plug_list, cfg.plug_count, sym_in);
		after_first  = rotor_forward(cfg.rotor_first, pos.p0, plugged);
		after_second = rotor_forward(cfg.rotor_second, pos.p1, after_first);
		sym_out      = rotor_forward(cfg.rotor_third, pos.p2, after_second);
	end

endmodule

### rtl/nrc_bwd_path.sv
module nrc_bwd_path (
	input  nrc_pkg::cipher_cfg_t cfg,
	input  nrc_pkg::rotor_pos_t  pos,
	input  nrc_pkg::nib_t        sym_in,
	output nrc_pkg::nib_t        sym_out
);
	import nrc_pkg::*;

	nib_t reflected;
	nib_t after_third;
	nib_t after_second;
	nib_t after_first;

	// Reflector, the rotors backward, then the plugboard once more.
	always_comb begin
		reflected    = entry_of(cfg.reflector, sym_in ^ nib_t'(1));
		after_third  = rotor_backward(cfg.rotor_third, pos.p2, reflected);
		after_second = rotor_backward(cfg.rotor_second, pos.p1, after_third);
		after_first  = rotor_backward(cfg.rotor_first, pos.p0, after_second);
		sym_out      = plugboard(cfg.plug_list, cfg.plug_count, after_first);
	end

endmodule

### rtl/nrc_checker.sv
module nrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_byte
);

	// With the output side free, the block always takes a new byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while the output side was free");

	// With no output stall, an accepted byte comes out as a valid result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing three cycles after its input transaction");

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_byte)))
		else $error("stalled result changed or dropped");

endmodule

bind nibble_rotor_cipher nrc_checker u_nrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_byte (result_byte)
);
